/* rtl/huffman_tree_decoder_top_macros.svh */
// ----------------------------------------------------------------------------
// Huffman tree decoder assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_DECODER_TOP_MACROS_SVH
`define HUFFMAN_TREE_DECODER_TOP_MACROS_SVH

// Checked outside reset only
`define HTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included
`define HTD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/htd_pkg.sv */
// ----------------------------------------------------------------------------
// htd_pkg
// Shared constants and types for the Huffman tree decoder.
// ----------------------------------------------------------------------------
package htd_pkg;

  // Default sizes
  localparam int MAX_CODE_LEN_DEF = 16;
  localparam int NODE_COUNT_DEF   = 512;

  // Field widths
  localparam int SYM_W       = 8;
  localparam int CODE_BITS_W = 16;
  localparam int CODE_LEN_W  = 5;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;

  // Operation kinds (tuser)
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [SYM_W-1:0]    sym;
    logic [STATUS_W-1:0] status;
  } res_t;

  // Sequencer to result stage
  typedef struct packed {
    logic push;    // new result into hold slot
    logic flush;   // hold slot out, marked last
    logic direct;  // result straight out, marked last
    res_t res;
  } res_ctl_t;

endpackage

/* rtl/htd_node_mem.sv */
// ----------------------------------------------------------------------------
// htd_node_mem
// Single write, single registered read node store ({left, right, symbol}).
// ----------------------------------------------------------------------------
module htd_node_mem #(
  parameter int DEPTH = 512,
  parameter int AW    = 9,
  parameter int DW    = 26
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/htd_result_q.sv */
// ----------------------------------------------------------------------------
// htd_result_q
// Hold slot plus output register; the hold slot lets the last result of a
// byte be tagged once the byte is done.
// ----------------------------------------------------------------------------
module htd_result_q (
  input  logic                                clk,
  input  logic                                rst,
  input  htd_pkg::res_ctl_t                   ctl,
  output logic                                out_free,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [htd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // [7:0] symbol_out, [9:8] status
  output logic                                m_axis_tlast
);
  import htd_pkg::*;

  logic hold_valid;
  res_t hold;
  res_t out_res;

  assign out_free     = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata = {{(OUT_TDATA_W - SYM_W - STATUS_W){1'b0}}, out_res.status, out_res.sym};

  // Controls are only raised while out_free is high
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      hold_valid    <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (ctl.push) begin
        if (hold_valid) begin
          out_res       <= hold;
          m_axis_tlast  <= 1'b0;
          m_axis_tvalid <= 1'b1;
        end
        hold       <= ctl.res;
        hold_valid <= 1'b1;
      end
      if (ctl.flush) begin
        if (hold_valid) begin
          out_res       <= hold;
          m_axis_tlast  <= 1'b1;
          m_axis_tvalid <= 1'b1;
        end
        hold_valid <= 1'b0;
      end
      if (ctl.direct) begin
        out_res       <= ctl.res;
        m_axis_tlast  <= 1'b1;
        m_axis_tvalid <= 1'b1;
      end
    end
  end

endmodule

/* rtl/htd_walk_seq.sv */
// ----------------------------------------------------------------------------
// htd_walk_seq
// Tree walk sequencer: steps one code or data bit at a time through the
// node store, allocating nodes on loads and emitting symbols on decodes.
// ----------------------------------------------------------------------------
module htd_walk_seq #(
  parameter int MAX_CODE_LEN = htd_pkg::MAX_CODE_LEN_DEF,
  parameter int NODE_COUNT   = htd_pkg::NODE_COUNT_DEF,
  parameter int AW           = $clog2(NODE_COUNT),
  parameter int DW           = 2 * AW + htd_pkg::SYM_W
) (
  input  logic                              clk,
  input  logic                              rst,
  // item in
  input  logic                              in_valid,
  output logic                              ready,
  input  logic                              op,
  input  logic [htd_pkg::SYM_W-1:0]         code_symbol,
  input  logic [htd_pkg::CODE_BITS_W-1:0]   code_bits,
  input  logic [htd_pkg::CODE_LEN_W-1:0]    code_len,
  input  logic [7:0]                        data_byte,
  // result stage
  input  logic                              out_free,
  output htd_pkg::res_ctl_t                 res_ctl,
  // node store
  output logic                              wr_en,
  output logic [AW-1:0]                     wr_addr,
  output logic [DW-1:0]                     wr_data,
  output logic                              rd_en,
  output logic [AW-1:0]                     rd_addr,
  input  logic [DW-1:0]                     rd_data
);
  import htd_pkg::*;

  localparam int LW = $clog2(MAX_CODE_LEN + 1);
  localparam int UW = $clog2(NODE_COUNT + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_D_FETCH,
    S_D_WALK,
    S_D_CHECK,
    S_D_FLUSH,
    S_L_WALK,
    S_L_NEW
  } state_t;

  state_t            state;
  logic [AW-1:0]     walk_node;
  logic [AW-1:0]     node;
  logic [UW-1:0]     nodes_used;
  logic              fresh;
  logic [2:0]        bit_cnt;
  logic [7:0]        byte_r;
  logic [SYM_W-1:0]  code_sym_r;
  logic [CODE_BITS_W-1:0] code_bits_r;
  logic [LW-1:0]     len_i;
  logic [AW-1:0]     root_left;
  logic [AW-1:0]     root_right;
  logic [SYM_W-1:0]  root_sym;

  logic [AW-1:0]     rd_left;
  logic [AW-1:0]     rd_right;
  logic [SYM_W-1:0]  rd_sym;
  logic [AW-1:0]     sel_node;
  logic [AW-1:0]     cur_left;
  logic [AW-1:0]     cur_right;
  logic [SYM_W-1:0]  cur_sym;
  logic [AW-1:0]     child_d;
  logic [CODE_BITS_W-1:0] code_sh;
  logic              ld_bit;
  logic [AW-1:0]     link_l;
  logic              leaf;
  logic              full;
  logic [AW-1:0]     new_idx;
  logic [LW-1:0]     len_sat;
  logic              go;

  assign ready = (state == S_IDLE);
  assign go    = out_free;

  // Row fields from the store
  assign {rd_left, rd_right, rd_sym} = rd_data;
  assign leaf = (rd_left == '0) && (rd_right == '0);

  // Current node row: root in registers, fresh node all zero, else store
  assign sel_node = (state == S_L_WALK) ? node : walk_node;
  always_comb begin
    if (sel_node == '0) begin
      cur_left  = root_left;
      cur_right = root_right;
      cur_sym   = root_sym;
    end else if (fresh) begin
      cur_left  = '0;
      cur_right = '0;
      cur_sym   = '0;
    end else begin
      cur_left  = rd_left;
      cur_right = rd_right;
      cur_sym   = rd_sym;
    end
  end

  // Branch selection for both walks
  assign child_d = byte_r[7] ? cur_right : cur_left;
  assign code_sh = code_bits_r >> (len_i - LW'(1));
  assign ld_bit  = code_sh[0];
  assign link_l  = ld_bit ? cur_right : cur_left;
  assign full    = (nodes_used >= UW'(NODE_COUNT));
  assign new_idx = nodes_used[AW-1:0];
  assign len_sat = (32'(code_len) > MAX_CODE_LEN) ? LW'(MAX_CODE_LEN) : LW'(code_len);

  // Store access and result controls
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = node;
    wr_data = '0;
    rd_en   = 1'b0;
    rd_addr = walk_node;
    res_ctl = '0;
    unique case (state)
      S_D_FETCH: begin
        rd_en = go && (walk_node != '0);
      end
      S_D_WALK: begin
        rd_addr = child_d;
        if (go) begin
          if (child_d == '0) begin
            res_ctl.push   = 1'b1;
            res_ctl.res    = '{sym: '0, status: ST_MISSING};
          end else begin
            rd_en = 1'b1;
          end
        end
      end
      S_D_CHECK: begin
        if (go && leaf) begin
          res_ctl.push = 1'b1;
          res_ctl.res  = '{sym: rd_sym, status: ST_OK};
        end
      end
      S_D_FLUSH: begin
        res_ctl.flush = go;
      end
      S_L_WALK: begin
        rd_addr = link_l;
        if (go) begin
          if (len_i == '0) begin
            wr_en   = (node != '0);
            wr_data = {cur_left, cur_right, code_sym_r};
          end else if (link_l != '0) begin
            rd_en = 1'b1;
          end else if (full) begin
            res_ctl.direct = 1'b1;
            res_ctl.res    = '{sym: '0, status: ST_FULL};
          end else begin
            wr_en   = (node != '0);
            wr_data = ld_bit ? {cur_left, new_idx, cur_sym} : {new_idx, cur_right, cur_sym};
          end
        end
      end
      S_L_NEW: begin
        wr_en   = go;
        wr_addr = new_idx;
        wr_data = '0;
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      walk_node  <= '0;
      nodes_used <= UW'(1);
      fresh      <= 1'b0;
      root_left  <= '0;
      root_right <= '0;
      root_sym   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            fresh <= 1'b0;
            if (op == OP_DECODE) begin
              byte_r  <= data_byte;
              bit_cnt <= '0;
              state   <= S_D_FETCH;
            end else begin
              code_sym_r  <= code_symbol;
              code_bits_r <= code_bits;
              len_i       <= len_sat;
              node        <= '0;
              state       <= S_L_WALK;
            end
          end
        end
        S_D_FETCH: begin
          if (go) begin
            state <= S_D_WALK;
          end
        end
        S_D_WALK: begin
          if (go) begin
            if (child_d == '0) begin
              // missing branch: restart at root, keep walking the byte
              walk_node <= '0;
              bit_cnt   <= bit_cnt + 3'd1;
              byte_r    <= {byte_r[6:0], 1'b0};
              state     <= (bit_cnt == 3'd7) ? S_D_FLUSH : S_D_WALK;
            end else begin
              node  <= child_d;
              state <= S_D_CHECK;
            end
          end
        end
        S_D_CHECK: begin
          if (go) begin
            walk_node <= leaf ? '0 : node;
            bit_cnt   <= bit_cnt + 3'd1;
            byte_r    <= {byte_r[6:0], 1'b0};
            state     <= (bit_cnt == 3'd7) ? S_D_FLUSH : S_D_WALK;
          end
        end
        S_D_FLUSH: begin
          if (go) begin
            state <= S_IDLE;
          end
        end
        S_L_WALK: begin
          if (go) begin
            if (len_i == '0) begin
              if (node == '0) begin
                root_sym <= code_sym_r;
              end
              fresh <= 1'b0;
              state <= S_IDLE;
            end else if (link_l != '0) begin
              node  <= link_l;
              fresh <= 1'b0;
              len_i <= len_i - LW'(1);
            end else if (full) begin
              fresh <= 1'b0;
              state <= S_IDLE;
            end else begin
              if (node == '0) begin
                if (ld_bit) begin
                  root_right <= new_idx;
                end else begin
                  root_left <= new_idx;
                end
              end
              state <= S_L_NEW;
            end
          end
        end
        S_L_NEW: begin
          if (go) begin
            node       <= new_idx;
            nodes_used <= nodes_used + UW'(1);
            fresh      <= 1'b1;
            len_i      <= len_i - LW'(1);
            state      <= S_L_WALK;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/huffman_tree_decoder_top.sv */
// ----------------------------------------------------------------------------
// huffman_tree_decoder_top
// Huffman decoder keeping its code table as a binary tree in a node store.
//
//   Channel  Dir  Fields                                           Ends
//   s_axis   in   tuser op; tdata code_symbol, code_bits,          item per
//                 code_len, data_byte                              transaction
//   m_axis   out  tdata symbol_out, status; tlast last             result per
//                                                                  transaction
//
// Decode: accept and fetch, then per bit a walk step, plus a check step when
//   the branch exists, which reads the registered read of the node store; a
//   flush step ends the byte.
// Load: one walk step per existing node on the path, a walk step and a
//   new-node step per new node, plus accept and the symbol write.
// Reset: root kept in registers, each node zeroed when allocated; no
//   clearing pass. Ready only between items.
// Stalls: the sequencer freezes while a result waits in the output register.
// ----------------------------------------------------------------------------
module huffman_tree_decoder_top #(
  parameter int MAX_CODE_LEN = htd_pkg::MAX_CODE_LEN_DEF,
  parameter int NODE_COUNT   = htd_pkg::NODE_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] code_symbol, [23:8] code_bits, [28:24] code_len, [36:29] data_byte
  input  logic [htd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic                              s_axis_tuser,  // [0] op
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [htd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // [7:0] symbol_out, [9:8] status
  output logic                              m_axis_tlast
);
  import htd_pkg::*;

  localparam int AW = $clog2(NODE_COUNT);
  localparam int DW = 2 * AW + SYM_W;

  res_ctl_t      res_ctl;
  logic          out_free;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] rd_data;

  // Sequencer
  htd_walk_seq #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .NODE_COUNT   (NODE_COUNT),
    .AW           (AW),
    .DW           (DW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .ready       (s_axis_tready),
    .op          (s_axis_tuser),
    .code_symbol (s_axis_tdata[7:0]),
    .code_bits   (s_axis_tdata[23:8]),
    .code_len    (s_axis_tdata[28:24]),
    .data_byte   (s_axis_tdata[36:29]),
    .out_free    (out_free),
    .res_ctl     (res_ctl),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  // Node store
  htd_node_mem #(
    .DEPTH (NODE_COUNT),
    .AW    (AW),
    .DW    (DW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Result stage
  htd_result_q u_res (
    .clk           (clk),
    .rst           (rst),
    .ctl           (res_ctl),
    .out_free      (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

/* rtl/htd_checker.sv */
// ----------------------------------------------------------------------------
// htd_checker
// Port-level checks for the Huffman tree decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "huffman_tree_decoder_top_macros.svh"

module htd_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [htd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input logic                              m_axis_tlast
);
  import htd_pkg::*;

  // No result survives reset
  `HTD_ASSERT_ALWAYS(a_rst_clears_out, rst |=> !m_axis_tvalid, "result valid after reset")

  // One item at a time: accepting drops ready
  `HTD_ASSERT(a_busy_after_accept, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "ready right after accept")

  // Error results carry a zero symbol and a known code
  `HTD_ASSERT(a_err_sym_zero, (m_axis_tvalid && (m_axis_tdata[9:8] != ST_OK)) |-> ((m_axis_tdata[7:0] == '0) && ((m_axis_tdata[9:8] == ST_MISSING) || (m_axis_tdata[9:8] == ST_FULL))), "bad error result")

  // A full store ends its load
  `HTD_ASSERT(a_full_is_last, (m_axis_tvalid && (m_axis_tdata[9:8] == ST_FULL)) |-> m_axis_tlast, "store full result not last")

endmodule

bind huffman_tree_decoder_top htd_checker u_htd_checker (.*);

/* bench/huffman_tree_decoder_top_tb.sv */
// ----------------------------------------------------------------------------
// huffman_tree_decoder_top_tb
// Self-checking bench for the Huffman tree decoder. Code loads and data
// bytes go in on the input stream. A local copy of the code tree predicts
// every decoded symbol, missing-branch error and store-full report. Each
// result transaction is checked field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module huffman_tree_decoder_top_tb;
  import htd_pkg::*;

  localparam int NODES       = NODE_COUNT_DEF;
  localparam int MAX_LEN     = MAX_CODE_LEN_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 60;

  // One input item, split into its fields
  typedef struct packed {
    logic                  op;
    logic [SYM_W-1:0]      code_symbol;
    logic [CODE_BITS_W-1:0] code_bits;
    logic [CODE_LEN_W-1:0] code_len;
    logic [7:0]            data_byte;
  } in_item_t;

  // One expected result
  typedef struct packed {
    logic [SYM_W-1:0]    sym;
    logic [STATUS_W-1:0] status;
    logic                last;
  } result_t;

  typedef enum int {RX_STEADY, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_t;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  // Local copy of the code tree
  logic [8:0]       tree_left  [NODES];
  logic [8:0]       tree_right [NODES];
  logic [SYM_W-1:0] tree_symbol[NODES];
  int               tree_used;
  int               tree_pos;

  result_t expected_results[$];

  int  cycles          = 0;
  int  mismatches      = 0;
  int  loads_sent      = 0;
  int  bytes_sent      = 0;
  int  full_predicted  = 0;
  int  symbols_seen    = 0;
  int  missing_seen    = 0;
  int  full_seen       = 0;
  int  burst_left      = 0;
  bit  tx_no_gaps      = 1'b0;
  bit  rx_hold_req     = 1'b0;

  huffman_tree_decoder_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) cycles <= cycles + 1;

  // Watchdog
  initial begin : watchdog
    wait (cycles >= CYCLE_LIMIT);
    $display("huffman_tree_decoder_top verification failed");
    $finish;
  end

  // Tree model: updates the local tree and queues the results of one item
  function automatic int predict_item(input in_item_t it);
    result_t    res[8];
    int         n;
    int         len;
    int         node;
    int         nxt;
    int         i;
    bit         b;
    bit         stopped;
    n = 0;
    if (it.op == OP_LOAD) begin
      len     = (it.code_len > MAX_LEN) ? MAX_LEN : int'(it.code_len);
      node    = 0;
      stopped = 1'b0;
      for (i = len - 1; i >= 0 && !stopped; i--) begin
        b   = it.code_bits[i];
        nxt = b ? int'(tree_right[node]) : int'(tree_left[node]);
        if (nxt == 0) begin
          if (tree_used >= NODES) begin
            // out of nodes: partial path stays, symbol not written
            res[0]  = '{sym: '0, status: ST_FULL, last: 1'b0};
            n       = 1;
            stopped = 1'b1;
            full_predicted++;
          end else begin
            nxt = tree_used;
            tree_used++;
            tree_left[nxt]   = '0;
            tree_right[nxt]  = '0;
            tree_symbol[nxt] = '0;
            if (b) tree_right[node] = nxt[8:0];
            else   tree_left[node]  = nxt[8:0];
          end
        end
        if (!stopped) node = nxt;
      end
      if (!stopped) tree_symbol[node] = it.code_symbol;
    end else begin
      for (i = 7; i >= 0; i--) begin
        b   = it.data_byte[i];
        nxt = b ? int'(tree_right[tree_pos]) : int'(tree_left[tree_pos]);
        if (nxt == 0) begin
          // missing branch: report and restart at the root
          res[n] = '{sym: '0, status: ST_MISSING, last: 1'b0};
          n++;
          tree_pos = 0;
        end else if (tree_left[nxt] == 0 && tree_right[nxt] == 0) begin
          res[n] = '{sym: tree_symbol[nxt], status: ST_OK, last: 1'b0};
          n++;
          tree_pos = 0;
        end else begin
          tree_pos = nxt;
        end
      end
    end
    for (i = 0; i < n; i++) begin
      res[i].last = (i == n - 1);
      expected_results.push_back(res[i]);
    end
    return n;
  endfunction

  function automatic in_item_t make_load(input logic [7:0] sym, input logic [15:0] bits,
                                         input logic [4:0] len);
    in_item_t it;
    it.op          = OP_LOAD;
    it.code_symbol = sym;
    it.code_bits   = bits;
    it.code_len    = len;
    it.data_byte   = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic in_item_t make_decode(input logic [7:0] data);
    in_item_t it;
    it.op          = OP_DECODE;
    it.code_symbol = 8'($urandom_range(0, 255));
    it.code_bits   = 16'($urandom_range(0, 65535));
    it.code_len    = 5'($urandom_range(0, 31));
    it.data_byte   = data;
    return it;
  endfunction

  // Send one item: bursts with random gaps, valid held across back-to-back items
  task automatic send_item(input in_item_t it);
    int gap;
    gap = 0;
    if (!tx_no_gaps) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tdata  <= {3'b000, it.data_byte, it.code_len, it.code_bits, it.code_symbol};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (it.op == OP_LOAD) loads_sent++;
    else                  bytes_sent++;
    void'(predict_item(it));
  endtask

  // Load a random complete prefix code of depth at most 8
  task automatic load_complete_code(input int splits);
    logic [15:0] cb[$];
    int          cl[$];
    int          k;
    int          pick;
    logic [15:0] b;
    int          l;
    cb.push_back('0);
    cl.push_back(0);
    for (k = 0; k < splits; k++) begin
      pick = $urandom_range(0, cb.size() - 1);
      if (cl[pick] < 8) begin
        b = cb[pick];
        l = cl[pick];
        cb.delete(pick);
        cl.delete(pick);
        cb.push_back({b[14:0], 1'b0});
        cl.push_back(l + 1);
        cb.push_back({b[14:0], 1'b1});
        cl.push_back(l + 1);
      end
    end
    foreach (cb[j]) send_item(make_load(8'($urandom_range(0, 255)), cb[j], 5'(cl[j])));
  endtask

  // Field extremes, empty-tree errors, saturated lengths, walk kept across loads
  task automatic test_directed_codes();
    send_item(make_decode(8'h00));                    // empty tree: all missing
    send_item(make_decode(8'hFF));
    send_item(make_load(8'h5A, 16'h0000, 5'd0));      // zero length: root symbol
    send_item(make_load(8'h00, 16'h0000, 5'd1));      // '0'
    send_item(make_load(8'hFF, 16'h0002, 5'd2));      // '10'
    send_item(make_load(8'h81, 16'h0006, 5'd3));      // '110'
    send_item(make_load(8'h7E, 16'hFFFF, 5'd16));     // longest all-ones code
    send_item(make_decode(8'h00));
    send_item(make_decode(8'hA5));                    // ends mid-code
    send_item(make_load(8'h3C, 16'h0001, 5'd31));     // saturated length
    send_item(make_decode(8'h7F));
    send_item(make_decode(8'hFF));
    send_item(make_decode(8'hFF));
    send_item(make_load(8'hC3, 16'h001F, 5'd5));      // symbol on an inner node
    send_item(make_decode(8'h00));
    send_item(make_load(8'h99, 16'h8000, 5'd17));
    send_item(make_load(8'h11, 16'h0000, 5'd16));
    send_item(make_load(8'h22, 16'h00E0, 5'd8));
    send_item(make_decode(8'h3C));
    send_item(make_decode(8'hC3));
    send_item(make_decode(8'h55));
    send_item(make_decode(8'hAA));
    send_item(make_decode(8'hE0));
  endtask

  // Mostly random data bytes, with stray loads mixed in
  task automatic mixed_traffic(input int count);
    int k;
    int r;
    for (k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 80)
        send_item(make_decode(8'($urandom_range(0, 255))));
      else if (r < 93)
        send_item(make_load(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                            5'($urandom_range(1, 8))));
      else
        send_item(make_load(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                            5'($urandom_range(9, 31))));
    end
  endtask

  task automatic test_random_traffic();
    load_complete_code(12);
    mixed_traffic(60);
    load_complete_code(10);
    mixed_traffic(60);
  endtask

  // Receiver holds off while the sender keeps pushing bytes
  task automatic test_output_backpressure();
    int k;
    tx_no_gaps  = 1'b1;
    rx_hold_req = 1'b1;
    for (k = 0; k < 16; k++) send_item(make_decode(8'($urandom_range(0, 255))));
    tx_no_gaps  = 1'b0;
  endtask

  // Long codes until the node store runs out, then decode on the full tree
  task automatic test_store_exhaustion();
    int k;
    k = 0;
    while (full_predicted < 4 && k < 150) begin
      send_item(make_load(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), 5'd16));
      if (k % 3 == 2) send_item(make_decode(8'($urandom_range(0, 255))));
      k++;
    end
    send_item(make_load(8'($urandom_range(0, 255)), 16'h0000, 5'd0));
    send_item(make_load(8'($urandom_range(0, 255)), 16'($urandom_range(0, 3)), 5'd2));
    for (k = 0; k < 10; k++) send_item(make_decode(8'($urandom_range(0, 255))));
  endtask

  // Receiver: stall pattern of its own, plus one long hold on request
  initial begin : rx_stall_gen
    rx_mode_t   mode;
    int         phase_left;
    int         hold_left;
    logic [7:0] pat;
    m_axis_tready = 1'b0;
    mode          = RX_STEADY;
    phase_left    = 0;
    hold_left     = 0;
    pat           = 8'b1011_0110;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = HOLD_CYCLES;
      end
      if (phase_left == 0) begin
        mode       = rx_mode_t'($urandom_range(0, 3));
        phase_left = $urandom_range(20, 120);
        pat        = 8'($urandom_range(1, 255));
      end else begin
        phase_left--;
      end
      pat = {pat[6:0], pat[7]};
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          RX_STEADY:  m_axis_tready <= 1'b1;
          RX_RANDOM:  m_axis_tready <= ($urandom_range(0, 99) < 60);
          RX_PATTERN: m_axis_tready <= pat[0];
          default:    m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Result checker
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with nothing expected: tdata=%h tlast=%b",
               m_axis_tdata, m_axis_tlast);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata[7:0] !== want.sym) begin
          $error("symbol_out: expected %h, got %h", want.sym, m_axis_tdata[7:0]);
          mismatches++;
        end
        if (m_axis_tdata[9:8] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tdata[9:8]);
          mismatches++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %b, got %b", want.last, m_axis_tlast);
          mismatches++;
        end
        case (want.status)
          ST_OK:      symbols_seen++;
          ST_MISSING: missing_seen++;
          default:    full_seen++;
        endcase
      end
    end
  end

  // Main sequence
  initial begin : main_seq
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_LOAD;
    rst           = 1'b1;
    for (int n = 0; n < NODES; n++) begin
      tree_left[n]   = '0;
      tree_right[n]  = '0;
      tree_symbol[n] = '0;
    end
    tree_used = 1;
    tree_pos  = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_codes();
    test_random_traffic();
    test_output_backpressure();
    test_store_exhaustion();

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d code loads and %0d data bytes; %0d nodes in use at the end.",
             loads_sent, bytes_sent, tree_used);
    $display("Checked %0d symbols, %0d missing-branch errors, %0d store-full reports.",
             symbols_seen, missing_seen, full_seen);
    if (mismatches == 0)
      $display("huffman_tree_decoder_top verification clean");
    else
      $display("huffman_tree_decoder_top verification failed");
    $finish;
  end

endmodule
